// ===== rtl/core/ppt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types, constants and helpers for the pure pursuit path tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int SEARCH_WINDOW_DEF = 80;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [31:0] cfg_word_t;
  typedef logic [2:0]  status_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_LOOKAHEAD   = 3'd0;
  localparam cfg_idx_t CFG_TRACK_WIDTH = 3'd1;
  localparam cfg_idx_t CFG_BAIL_DIST   = 3'd2;
  localparam cfg_idx_t CFG_TIMEOUT     = 3'd3;
  localparam cfg_idx_t CFG_POINT_COUNT = 3'd4;

  // Result status codes.
  localparam status_t ST_LOADED    = 3'd0;
  localparam status_t ST_RUNNING   = 3'd1;
  localparam status_t ST_SUCCESS   = 3'd2;
  localparam status_t ST_BAIL      = 3'd3;
  localparam status_t ST_TIMEOUT   = 3'd4;
  localparam status_t ST_START_FAR = 3'd5;
  localparam status_t ST_EMPTY     = 3'd6;

  // Configuration reset values.
  localparam logic [15:0] LOOKAHEAD_RST   = 16'd3072;
  localparam logic [15:0] TRACK_WIDTH_RST = 16'd3072;
  localparam logic [19:0] BAIL_DIST_RST   = 20'd1536;

  // Point word layout in the point memory: x, y, speed, accel.
  localparam int PT_W = 88;

  localparam logic [39:0] START_TOL2    = 40'd589824;
  localparam logic [39:0] END_TOL2      = 40'd589824;
  localparam logic [19:0] END_TOL       = 20'd768;
  localparam logic [31:0] BAIL_HOLD_MS  = 32'd150;
  localparam logic [31:0] TIMEOUT_PAD   = 32'd500;
  localparam logic [63:0] KAPPA_LIMIT   = 64'd1 << 34;

  localparam int          CORDIC_STEPS    = 15;
  localparam logic signed [19:0] CORDIC_INV_GAIN = 20'sd39797;

  localparam int D2_W   = 51;
  localparam int SQ_W   = 52;
  localparam int ROOT_W = 26;
  localparam int DIV_W  = 64;

  function automatic logic [13:0] cordic_atan(input logic [3:0] k);
    logic [13:0] a;
    case (k)
      4'd0:  a = 14'd8192;
      4'd1:  a = 14'd4836;
      4'd2:  a = 14'd2555;
      4'd3:  a = 14'd1297;
      4'd4:  a = 14'd651;
      4'd5:  a = 14'd326;
      4'd6:  a = 14'd163;
      4'd7:  a = 14'd81;
      4'd8:  a = 14'd41;
      4'd9:  a = 14'd20;
      4'd10: a = 14'd10;
      4'd11: a = 14'd5;
      4'd12: a = 14'd3;
      4'd13: a = 14'd1;
      4'd14: a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [40:0] v);
    logic signed [19:0] r;
    if (v > 41'sd524287) begin
      r = 20'sd524287;
    end else if (v < -41'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pure_pursuit_path_tracker.sv =====
`timescale 1ns / 1ps
// A load word answers in the next cycle. A pose tick runs longer with W, the
// search window walked, and with C, the chords walked to the carrot, since the
// bit-serial square root runs once per chord and the divider at most once per tick.
// The next word is accepted in the cycle its result shows.
// Synchronous reset clears the run state and restores the register defaults;
// the point memory is not cleared. The result strobe is not back-pressured.
// ----------------------------------------------------------------------------
// pure_pursuit_path_tracker
// Point store plus a sequencer for nearest search, carrot walk and steering.
// ----------------------------------------------------------------------------
module pure_pursuit_path_tracker #(
  parameter int MAX_POINTS    = ppt_pkg::MAX_POINTS_DEF,
  parameter int SEARCH_WINDOW = ppt_pkg::SEARCH_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  ppt_pkg::cfg_idx_t     cfg_index,
  input  ppt_pkg::cfg_word_t    cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [9:0]            point_index,
  input  logic signed [23:0]    x_pos,
  input  logic signed [23:0]    y_pos,
  input  logic [15:0]           heading,
  input  logic signed [19:0]    point_speed,
  input  logic signed [19:0]    point_accel,
  input  logic [31:0]           time_ms,
  output logic                  done,
  output ppt_pkg::status_t      status,
  output logic signed [19:0]    left_speed,
  output logic signed [19:0]    right_speed,
  output logic signed [19:0]    accel_target,
  output logic [9:0]            closest_index,
  output logic [9:0]            carrot_index,
  output logic [23:0]           closest_error
);
  import ppt_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_ST_RD   = 5'd1;
  localparam logic [4:0] S_ST_SQ   = 5'd2;
  localparam logic [4:0] S_ST_CMP  = 5'd3;
  localparam logic [4:0] S_TMO     = 5'd4;
  localparam logic [4:0] S_SR_RD   = 5'd5;
  localparam logic [4:0] S_SR_SQ   = 5'd6;
  localparam logic [4:0] S_SR_CMP  = 5'd7;
  localparam logic [4:0] S_NS_GO   = 5'd8;
  localparam logic [4:0] S_NS_WAIT = 5'd9;
  localparam logic [4:0] S_BAIL    = 5'd10;
  localparam logic [4:0] S_WK_INIT = 5'd11;
  localparam logic [4:0] S_WK_RD0  = 5'd12;
  localparam logic [4:0] S_WK_PREV = 5'd13;
  localparam logic [4:0] S_WK_RD   = 5'd14;
  localparam logic [4:0] S_WK_SQ   = 5'd15;
  localparam logic [4:0] S_WK_SUM  = 5'd16;
  localparam logic [4:0] S_WK_WAIT = 5'd17;
  localparam logic [4:0] S_CR_RD   = 5'd18;
  localparam logic [4:0] S_CR_SQ   = 5'd19;
  localparam logic [4:0] S_CR_SUM  = 5'd20;
  localparam logic [4:0] S_CORDIC  = 5'd21;
  localparam logic [4:0] S_EL_MUL  = 5'd22;
  localparam logic [4:0] S_EL_SUB  = 5'd23;
  localparam logic [4:0] S_DIV_WT  = 5'd24;
  localparam logic [4:0] S_WH_MUL1 = 5'd25;
  localparam logic [4:0] S_WH_MUL2 = 5'd26;
  localparam logic [4:0] S_WH_OUT  = 5'd27;
  localparam logic [4:0] S_END_RD  = 5'd28;
  localparam logic [4:0] S_END_SQ  = 5'd29;
  localparam logic [4:0] S_END_CMP = 5'd30;

  logic [4:0] state;

  // Configuration registers.
  logic [15:0] lookahead;
  logic [15:0] track_width;
  logic [19:0] bail_distance;
  logic [31:0] timeout_ms;
  logic [10:0] point_count;

  // Run state.
  logic          running;
  logic          end_reached;
  logic          bail_armed;
  logic [31:0]   bail_start_ms;
  logic [31:0]   run_start_ms;
  logic [AW-1:0] nearest_idx;

  // Per-tick working registers.
  logic signed [23:0] px;
  logic signed [23:0] py;
  logic [15:0]        hd;
  logic [31:0]        now;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      srch_end;
  logic [AW-1:0]      best;
  logic [D2_W-1:0]    best2;
  logic signed [19:0] best_speed;
  logic [19:0]        best_accel;
  logic [23:0]        err;
  logic [39:0]        b2;
  logic [26:0]        cum;
  logic [AW-1:0]      carrot;
  logic signed [23:0] prev_x;
  logic signed [23:0] prev_y;
  logic [49:0]        sqx;
  logic [49:0]        sqy;
  logic signed [24:0] dxr;
  logic signed [24:0] dyr;
  logic [D2_W-1:0]    d2c;
  logic signed [19:0] cx;
  logic signed [19:0] cy;
  logic signed [17:0] cz;
  logic [3:0]         ck;
  logic               cneg;
  logic signed [44:0] pa;
  logic signed [44:0] pb;
  logic               kneg;
  logic signed [35:0] kappa;
  logic signed [55:0] m1;
  logic signed [63:0] m2;
  logic signed [19:0] wl;
  logic signed [19:0] wr;

  // Point memory.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [PT_W-1:0] ram_wdata;
  logic [PT_W-1:0] ram_rdata;
  logic [31:0]     pidx32;
  logic            accept;

  assign accept    = start && !busy;
  assign pidx32    = 32'(point_index);
  assign ram_we    = accept && !req_type && (pidx32 < 32'(MAX_POINTS));
  assign ram_waddr = pidx32[AW-1:0];
  assign ram_wdata = {x_pos, y_pos, point_speed, point_accel};

  ppt_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  logic signed [23:0] rd_x;
  logic signed [23:0] rd_y;
  logic signed [19:0] rd_speed;
  logic [19:0]        rd_accel;

  assign rd_x     = ram_rdata[87:64];
  assign rd_y     = ram_rdata[63:40];
  assign rd_speed = ram_rdata[39:20];
  assign rd_accel = ram_rdata[19:0];

  // Shared distance path: difference to the robot, or to the previous point on the walk.
  logic signed [23:0] ref_x;
  logic signed [23:0] ref_y;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [49:0] dx_sq;
  logic signed [49:0] dy_sq;
  logic [D2_W-1:0]    d2_sum;

  assign ref_x  = (state == S_WK_SQ) ? prev_x : px;
  assign ref_y  = (state == S_WK_SQ) ? prev_y : py;
  assign dx     = {rd_x[23], rd_x} - {ref_x[23], ref_x};
  assign dy     = {rd_y[23], rd_y} - {ref_y[23], ref_y};
  assign dx_sq  = dx * dx;
  assign dy_sq  = dy * dy;
  assign d2_sum = {1'b0, sqx} + {1'b0, sqy};

  // Point counts.
  logic [31:0]   pc32;
  logic [CW-1:0] n_pts;
  logic [CW-1:0] last;
  logic [31:0]   last32;
  logic [31:0]   limit;
  logic [31:0]   near32;
  logic [CW-1:0] nclamp;
  logic [31:0]   win_end;

  assign pc32    = 32'(point_count);
  assign n_pts   = (pc32 > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc32[CW-1:0];
  assign last    = n_pts - 1'b1;
  assign last32  = 32'(last);
  assign limit   = (timeout_ms != '0) ? timeout_ms
                 : (last32 << 3) + (last32 << 1) + TIMEOUT_PAD;
  assign near32  = 32'(nearest_idx);
  assign nclamp  = (near32 > last32) ? last : near32[CW-1:0];
  assign win_end = ((32'(nclamp) + 32'(SEARCH_WINDOW)) > 32'(n_pts)) ? 32'(n_pts)
                 : 32'(nclamp) + 32'(SEARCH_WINDOW);

  // Square root and divider units.
  logic              sq_go;
  logic [SQ_W-1:0]   sq_in;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic [ROOT_W:0]   sq_rem;

  assign sq_go = (state == S_NS_GO) || (state == S_WK_SUM);
  assign sq_in = (state == S_NS_GO) ? SQ_W'(best2) : SQ_W'(d2_sum);

  ppt_sqrt #(
    .IN_W (SQ_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sq_go),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root),
    .rem      (sq_rem)
  );

  logic signed [45:0] elat;
  logic [45:0]        elat_mag;
  logic               dv_go;
  logic [DIV_W-1:0]   dv_num;
  logic               dv_done;
  logic [DIV_W-1:0]   dv_quot;
  logic [DIV_W-1:0]   kmag;

  assign elat     = {pa[44], pa} - {pb[44], pb};
  assign elat_mag = elat[45] ? 46'(-elat) : elat;
  assign dv_go    = (state == S_EL_SUB) && (d2c != '0);
  assign dv_num   = DIV_W'(elat_mag) << 17;
  assign kmag     = (dv_quot > KAPPA_LIMIT) ? KAPPA_LIMIT : dv_quot;

  ppt_div #(
    .NUM_W (DIV_W),
    .DEN_W (D2_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (dv_go),
    .num  (dv_num),
    .den  (d2c),
    .done (dv_done),
    .quot (dv_quot)
  );

  // Walk step: chord rounded to nearest, then accumulated.
  logic [26:0] chord;
  logic [26:0] cum_next;

  assign chord    = ({1'b0, sq_rem} > 27'(sq_root)) ? 27'(sq_root) + 27'd1 : 27'(sq_root);
  assign cum_next = cum + chord;

  // CORDIC step.
  logic signed [19:0] c_xs;
  logic signed [19:0] c_ys;
  logic signed [17:0] c_at;
  logic signed [17:0] z0;
  logic signed [19:0] cs_val;
  logic signed [19:0] sn_val;

  assign c_xs   = cy >>> ck;
  assign c_ys   = cx >>> ck;
  assign c_at   = 18'(cordic_atan(ck));
  assign z0     = {{2{hd[15]}}, hd};
  assign cs_val = cneg ? -cx : cx;
  assign sn_val = cneg ? -cy : cy;

  // Wheel terms.
  logic signed [39:0] delta;
  logic signed [46:0] m1_sh;

  assign m1_sh = m1[55:9];
  assign delta = m2[63:24];

  logic [39:0]     lim2;
  logic [D2_W+1:0] d2_x4;

  assign lim2  = (bail_distance < END_TOL) ? b2 : END_TOL2;
  assign d2_x4 = {d2_sum, 2'b00};

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LOOKAHEAD_RST;
      track_width <= TRACK_WIDTH_RST;
      bail_distance <= BAIL_DIST_RST;
      timeout_ms <= '0;
      point_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOKAHEAD:   lookahead <= cfg_data[15:0];
        CFG_TRACK_WIDTH: track_width <= cfg_data[15:0];
        CFG_BAIL_DIST:   bail_distance <= cfg_data[19:0];
        CFG_TIMEOUT:     timeout_ms <= cfg_data;
        CFG_POINT_COUNT: point_count <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      running       <= 1'b0;
      end_reached   <= 1'b0;
      bail_armed    <= 1'b0;
      bail_start_ms <= '0;
      run_start_ms  <= '0;
      nearest_idx   <= '0;
      ptr           <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // Result fields start from zero; terminal states fill in what they give.
            status        <= ST_LOADED;
            left_speed    <= '0;
            right_speed   <= '0;
            accel_target  <= '0;
            closest_index <= '0;
            carrot_index  <= '0;
            closest_error <= '0;
            px  <= x_pos;
            py  <= y_pos;
            hd  <= heading;
            now <= time_ms;
            if (!req_type) begin
              done <= 1'b1;
            end else if (n_pts < CW'(2)) begin
              running <= 1'b0;
              status  <= ST_EMPTY;
              done    <= 1'b1;
            end else if (!running) begin
              ptr   <= '0;
              state <= S_ST_RD;
            end else begin
              state <= S_TMO;
            end
          end
        end
        S_ST_RD: state <= S_ST_SQ;
        S_ST_SQ: begin
          sqx   <= dx_sq[49:0];
          sqy   <= dy_sq[49:0];
          state <= S_ST_CMP;
        end
        S_ST_CMP: begin
          if (d2_sum > D2_W'(START_TOL2)) begin
            status <= ST_START_FAR;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            running       <= 1'b1;
            run_start_ms  <= now;
            nearest_idx   <= '0;
            end_reached   <= 1'b0;
            bail_armed    <= 1'b0;
            bail_start_ms <= '0;
            state         <= S_TMO;
          end
        end
        S_TMO: begin
          if ((now - run_start_ms) > limit) begin
            running <= 1'b0;
            status  <= ST_TIMEOUT;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            ptr      <= nclamp;
            best     <= nclamp[AW-1:0];
            best2    <= '1;
            srch_end <= win_end[CW-1:0];
            b2       <= bail_distance * bail_distance;
            state    <= S_SR_RD;
          end
        end
        S_SR_RD: state <= S_SR_SQ;
        S_SR_SQ: begin
          sqx   <= dx_sq[49:0];
          sqy   <= dy_sq[49:0];
          state <= S_SR_CMP;
        end
        S_SR_CMP: begin
          if (d2_sum < best2) begin
            best2      <= d2_sum;
            best       <= ptr[AW-1:0];
            best_speed <= rd_speed;
            best_accel <= rd_accel;
          end
          if (ptr + 1'b1 == srch_end) begin
            state <= S_NS_GO;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_NS_GO: begin
          nearest_idx <= best;
          state       <= S_NS_WAIT;
        end
        S_NS_WAIT: begin
          if (sq_done) begin
            err   <= (sq_root > ROOT_W'(24'hFFFFFF)) ? 24'hFFFFFF : sq_root[23:0];
            state <= S_BAIL;
          end
        end
        S_BAIL: begin
          state <= S_WK_INIT;
          if (best2 > D2_W'(b2)) begin
            if (!bail_armed) begin
              bail_armed    <= 1'b1;
              bail_start_ms <= now;
            end else if ((now - bail_start_ms) > BAIL_HOLD_MS) begin
              running       <= 1'b0;
              status        <= ST_BAIL;
              closest_index <= 10'(32'(best));
              closest_error <= err;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            bail_armed <= 1'b0;
          end
        end
        S_WK_INIT: begin
          carrot <= last[AW-1:0];
          cum    <= '0;
          if (32'(best) >= last32) begin
            end_reached <= 1'b1;
            ptr         <= last;
            state       <= S_CR_RD;
          end else begin
            ptr   <= CW'(best);
            state <= S_WK_RD0;
          end
        end
        S_WK_RD0: state <= S_WK_PREV;
        S_WK_PREV: begin
          prev_x <= rd_x;
          prev_y <= rd_y;
          ptr    <= ptr + 1'b1;
          state  <= S_WK_RD;
        end
        S_WK_RD: state <= S_WK_SQ;
        S_WK_SQ: begin
          sqx    <= dx_sq[49:0];
          sqy    <= dy_sq[49:0];
          prev_x <= rd_x;
          prev_y <= rd_y;
          state  <= S_WK_SUM;
        end
        S_WK_SUM: state <= S_WK_WAIT;
        S_WK_WAIT: begin
          if (sq_done) begin
            cum <= cum_next;
            if (cum_next >= 27'(lookahead)) begin
              carrot <= ptr[AW-1:0];
              state  <= S_CR_RD;
            end else if (ptr == last) begin
              end_reached <= 1'b1;
              state       <= S_CR_RD;
            end else begin
              ptr   <= ptr + 1'b1;
              state <= S_WK_RD;
            end
          end
        end
        S_CR_RD: begin
          ptr   <= CW'(carrot);
          state <= S_CR_SQ;
        end
        S_CR_SQ: begin
          // The pointer already holds the carrot in the read state above; its data arrives here.
          sqx   <= dx_sq[49:0];
          sqy   <= dy_sq[49:0];
          dxr   <= dx;
          dyr   <= dy;
          state <= S_CR_SUM;
        end
        S_CR_SUM: begin
          d2c <= d2_sum;
          cx  <= CORDIC_INV_GAIN;
          cy  <= '0;
          ck  <= '0;
          if (z0 > 18'sd16384) begin
            cz   <= z0 - 18'sd32768;
            cneg <= 1'b1;
          end else if (z0 < -18'sd16384) begin
            cz   <= z0 + 18'sd32768;
            cneg <= 1'b1;
          end else begin
            cz   <= z0;
            cneg <= 1'b0;
          end
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cz >= 0) begin
            cx <= cx - c_xs;
            cy <= cy + c_ys;
            cz <= cz - c_at;
          end else begin
            cx <= cx + c_xs;
            cy <= cy - c_ys;
            cz <= cz + c_at;
          end
          ck <= ck + 1'b1;
          if (ck == 4'(CORDIC_STEPS - 1)) begin
            state <= S_EL_MUL;
          end
        end
        S_EL_MUL: begin
          pa    <= cs_val * dxr;
          pb    <= sn_val * dyr;
          state <= S_EL_SUB;
        end
        S_EL_SUB: begin
          kneg <= elat[45];
          if (d2c == '0) begin
            kappa <= '0;
            state <= S_WH_MUL1;
          end else begin
            state <= S_DIV_WT;
          end
        end
        S_DIV_WT: begin
          if (dv_done) begin
            kappa <= kneg ? -$signed(kmag[35:0]) : $signed(kmag[35:0]);
            state <= S_WH_MUL1;
          end
        end
        S_WH_MUL1: begin
          m1    <= best_speed * kappa;
          state <= S_WH_MUL2;
        end
        S_WH_MUL2: begin
          m2    <= m1_sh * $signed({1'b0, track_width});
          state <= S_WH_OUT;
        end
        S_WH_OUT: begin
          wl            <= sat20(41'(best_speed) + 41'(delta));
          wr            <= sat20(41'(best_speed) - 41'(delta));
          left_speed    <= sat20(41'(best_speed) + 41'(delta));
          right_speed   <= sat20(41'(best_speed) - 41'(delta));
          accel_target  <= best_accel;
          closest_index <= 10'(32'(best));
          carrot_index  <= 10'(32'(carrot));
          closest_error <= err;
          status        <= ST_RUNNING;
          if (end_reached) begin
            ptr   <= last;
            state <= S_END_RD;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_END_RD: state <= S_END_SQ;
        S_END_SQ: begin
          sqx   <= dx_sq[49:0];
          sqy   <= dy_sq[49:0];
          state <= S_END_CMP;
        end
        S_END_CMP: begin
          if (d2_x4 < (D2_W+2)'(lim2)) begin
            running <= 1'b0;
            status  <= ST_SUCCESS;
          end
          left_speed  <= wl;
          right_speed <= wr;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ppt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ppt_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_sqrt
// Bit-serial integer square root, one root bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module ppt_sqrt #(
  parameter int IN_W = 52
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [IN_W-1:0]     radicand,
  output logic                done,
  output logic [IN_W/2-1:0]   root,
  output logic [IN_W/2:0]     rem
);

  localparam int RW  = IN_W / 2;
  localparam int CNW = $clog2(RW + 1);

  logic [IN_W-1:0] v;
  logic [IN_W-1:0] r;
  logic [IN_W-1:0] bitv;
  logic [CNW-1:0]  cnt;
  logic            active;
  logic [IN_W:0]   trial;

  assign trial = {1'b0, r} + {1'b0, bitv};
  assign root  = r[RW-1:0];
  assign rem   = v[RW:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        v      <= radicand;
        r      <= '0;
        bitv   <= {2'b01, {(IN_W-2){1'b0}}};
        cnt    <= CNW'(RW);
        active <= 1'b1;
      end else if (active) begin
        if ({1'b0, v} >= trial) begin
          v <= v - trial[IN_W-1:0];
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ppt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppt_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 51
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [CNW-1:0]   cnt;
  logic             active;
  logic [DEN_W:0]   shifted;

  assign shifted = {rem, quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quot   <= num;
        den_r  <= den;
        rem    <= '0;
        cnt    <= CNW'(NUM_W);
        active <= 1'b1;
      end else if (active) begin
        // The partial remainder stays below the divisor, so one compare suffices.
        if (shifted >= {1'b0, den_r}) begin
          rem  <= DEN_W'(shifted - {1'b0, den_r});
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= shifted[DEN_W-1:0];
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ppt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_checker
// Port-level checks for the path tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ppt_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               req_type,
  input logic               done,
  input ppt_pkg::status_t   status,
  input logic signed [19:0] left_speed,
  input logic signed [19:0] right_speed,
  input logic [9:0]         carrot_index,
  input logic [23:0]        closest_error
);
  import ppt_pkg::*;

  // A result word never overlaps work on the next word.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A load word answers in the very next cycle.
  a_load_ack: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !req_type) |=> (done && status == ST_LOADED))
    else $error("load word not acknowledged");

  // A result only follows an accepted word or ongoing work.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("unsolicited result word");

  // Aborted ticks carry no steering.
  a_abort_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_TIMEOUT || status == ST_START_FAR || status == ST_EMPTY))
      |-> (left_speed == 0 && right_speed == 0 && carrot_index == 0
           && closest_error == 0))
    else $error("aborted tick with nonzero fields");

  // An accepted pose tick keeps the block busy or answers at once.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type) |=> (busy || done))
    else $error("pose tick dropped");

endmodule

bind pure_pursuit_path_tracker ppt_checker u_ppt_checker (.*);

// ===== tb/ppt_tracker_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_tracker_check
// Watches the command, register and result ports of the path tracker, keeps
// its own copy of the point store and run state, predicts every result word
// and compares it field by field against what the block delivers.
// ----------------------------------------------------------------------------
module ppt_tracker_check
  import ppt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  cfg_word_t          cfg_data,
  input  logic               start,
  input  logic               busy,
  input  logic               req_type,
  input  logic [9:0]         point_index,
  input  logic signed [23:0] x_pos,
  input  logic signed [23:0] y_pos,
  input  logic [15:0]        heading,
  input  logic signed [19:0] point_speed,
  input  logic signed [19:0] point_accel,
  input  logic [31:0]        time_ms,
  input  logic               done,
  input  status_t            status,
  input  logic signed [19:0] left_speed,
  input  logic signed [19:0] right_speed,
  input  logic signed [19:0] accel_target,
  input  logic [9:0]         closest_index,
  input  logic [9:0]         carrot_index,
  input  logic [23:0]        closest_error,
  output int                 fail_count,
  output int                 pending,
  output int                 words_checked
);

  typedef struct packed {
    status_t            st;
    logic signed [19:0] lspd;
    logic signed [19:0] rspd;
    logic signed [19:0] acc;
    logic [9:0]         near_i;
    logic [9:0]         carrot_i;
    logic [23:0]        err;
  } steer_word_t;

  steer_word_t steer_expected[$];

  logic signed [23:0] mem_x [1024];
  logic signed [23:0] mem_y [1024];
  logic signed [19:0] mem_spd [1024];
  logic signed [19:0] mem_acc [1024];

  int unsigned near_pt;
  bit          running, end_seen, bail_on;
  logic [31:0] bail_t0, run_t0;
  logic [15:0] look_r, track_r;
  logic [19:0] bail_r;
  logic [31:0] tmo_r;
  logic [10:0] count_r;

  int heading_atan [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

  initial begin
    fail_count = 0;
    pending = 0;
    words_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic field_check(input string nm, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", nm, got, want));
    end
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sq_dist(input longint ax, input longint ay,
                                              input longint bx, input longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic logic signed [19:0] clip20(input longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  // Q16 sine and cosine of a binary angle; the far half-plane is folded back
  // and the result negated.
  task automatic heading_trig(input logic [15:0] hd, output longint c, output longint s);
    int     z;
    bit     flip;
    longint x, y, xs, ys;
    z = hd;
    flip = 0;
    x = CORDIC_INV_GAIN;
    y = 0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768;
      flip = 1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1;
    end
    for (int k = 0; k < 15; k++) begin
      xs = y >>> k;
      ys = x >>> k;
      if (z >= 0) begin
        x -= xs;
        y += ys;
        z -= heading_atan[k];
      end else begin
        x += xs;
        y -= ys;
        z += heading_atan[k];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic steer_step(input longint px, input longint py, input logic [15:0] hd,
                            input logic [31:0] now, output steer_word_t r);
    int unsigned     n, lastp, i, best, stop, carrot;
    longint          cs, sn, dx, dy, elat, v, kap, dl;
    longint unsigned d2, best2, cum, c2, rt, b2, lim2;
    logic [31:0]     lim;
    r = '0;
    n = (count_r > 1024) ? 1024 : count_r;
    if (n < 2) begin
      running = 0;
      r.st = ST_EMPTY;
      return;
    end
    lastp = n - 1;
    if (!running) begin
      if (sq_dist(mem_x[0], mem_y[0], px, py) > 589824) begin
        r.st = ST_START_FAR;
        return;
      end
      running = 1;
      run_t0 = now;
      near_pt = 0;
      end_seen = 0;
      bail_on = 0;
      bail_t0 = 0;
    end
    lim = (tmo_r != 0) ? tmo_r : 32'(10 * lastp + 500);
    if (32'(now - run_t0) > lim) begin
      running = 0;
      r.st = ST_TIMEOUT;
      return;
    end

    if (near_pt > lastp) near_pt = lastp;
    best = near_pt;
    stop = near_pt + 80;
    if (stop > n) stop = n;
    best2 = '1;
    for (i = near_pt; i < stop; i++) begin
      d2 = sq_dist(mem_x[i], mem_y[i], px, py);
      if (d2 < best2) begin
        best2 = d2;
        best = i;
      end
    end
    near_pt = best;
    d2 = root_floor(best2);
    r.near_i = best[9:0];
    r.err = (d2 > 64'hFF_FFFF) ? 24'hFF_FFFF : d2[23:0];

    b2 = longint'(bail_r) * longint'(bail_r);
    if (best2 > b2) begin
      if (!bail_on) begin
        bail_on = 1;
        bail_t0 = now;
      end else if (32'(now - bail_t0) > 150) begin
        running = 0;
        r.st = ST_BAIL;
        return;
      end
    end else begin
      bail_on = 0;
    end

    // Walk rounded chord lengths until the lookahead is covered.
    carrot = lastp;
    cum = 0;
    for (i = best; i < lastp; i++) begin
      c2 = sq_dist(mem_x[i+1], mem_y[i+1], mem_x[i], mem_y[i]);
      rt = root_floor(c2);
      if (c2 - rt * rt > rt) rt++;
      cum += rt;
      if (cum >= look_r) begin
        carrot = i + 1;
        break;
      end
    end
    if (i >= lastp) end_seen = 1;

    dx = longint'(mem_x[carrot]) - px;
    dy = longint'(mem_y[carrot]) - py;
    heading_trig(hd, cs, sn);
    d2 = dx * dx + dy * dy;
    kap = 0;
    if (d2 > 0) begin
      elat = cs * dx - sn * dy;
      kap = (elat * 131072) / longint'(d2);
      if (kap > (64'sd1 <<< 34)) kap = 64'sd1 <<< 34;
      if (kap < -(64'sd1 <<< 34)) kap = -(64'sd1 <<< 34);
    end
    v = mem_spd[best];
    dl = (((v * kap) >>> 9) * longint'(track_r)) >>> 24;
    r.lspd = clip20(v + dl);
    r.rspd = clip20(v - dl);
    r.acc = mem_acc[best];
    r.carrot_i = carrot[9:0];
    r.st = ST_RUNNING;

    if (end_seen) begin
      d2 = sq_dist(mem_x[lastp], mem_y[lastp], px, py);
      lim2 = (bail_r < 768) ? b2 : 64'd589824;
      if (4 * d2 < lim2) begin
        running = 0;
        r.st = ST_SUCCESS;
      end
    end
  endtask

  always @(posedge clk) begin
    steer_word_t want;
    if (rst) begin
      steer_expected.delete();
      near_pt = 0;
      running = 0;
      end_seen = 0;
      bail_on = 0;
      bail_t0 = 0;
      run_t0 = 0;
      look_r = LOOKAHEAD_RST;
      track_r = TRACK_WIDTH_RST;
      bail_r = BAIL_DIST_RST;
      tmo_r = 0;
      count_r = 0;
    end else begin
      if (done) begin
        if (steer_expected.size() == 0) begin
          report_mismatch("result word with no prediction waiting");
        end else begin
          want = steer_expected.pop_front();
          field_check("status", status, want.st);
          field_check("left_speed", left_speed, want.lspd);
          field_check("right_speed", right_speed, want.rspd);
          field_check("accel_target", accel_target, want.acc);
          field_check("closest_index", closest_index, want.near_i);
          field_check("carrot_index", carrot_index, want.carrot_i);
          field_check("closest_error", closest_error, want.err);
          words_checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOOKAHEAD:   look_r = cfg_data[15:0];
          CFG_TRACK_WIDTH: track_r = cfg_data[15:0];
          CFG_BAIL_DIST:   bail_r = cfg_data[19:0];
          CFG_TIMEOUT:     tmo_r = cfg_data;
          CFG_POINT_COUNT: count_r = cfg_data[10:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (!req_type) begin
          mem_x[point_index] = x_pos;
          mem_y[point_index] = y_pos;
          mem_spd[point_index] = point_speed;
          mem_acc[point_index] = point_accel;
          want = '0;
          want.st = ST_LOADED;
        end else begin
          steer_step(x_pos, y_pos, heading, time_ms, want);
        end
        steer_expected.push_back(want);
      end
    end
    pending <= steer_expected.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the path tracker with point loads, register writes and pose ticks
// along random trajectories, with noise and off-path excursions mixed in.
// ----------------------------------------------------------------------------
module tb_top;
  import ppt_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  cfg_idx_t           cfg_index = CFG_LOOKAHEAD;
  cfg_word_t          cfg_data = '0;
  logic               start = 0;
  logic               busy;
  logic               req_type = 0;
  logic [9:0]         point_index = '0;
  logic signed [23:0] x_pos = '0;
  logic signed [23:0] y_pos = '0;
  logic [15:0]        heading = '0;
  logic signed [19:0] point_speed = '0;
  logic signed [19:0] point_accel = '0;
  logic [31:0]        time_ms = '0;
  logic               done;
  status_t            status;
  logic signed [19:0] left_speed, right_speed, accel_target;
  logic [9:0]         closest_index, carrot_index;
  logic [23:0]        closest_error;

  int fail_count, pending, words_checked;
  int idle_pct, tick_words, load_words, reg_writes;
  int path_x [1024];
  int path_y [1024];

  always #5 clk = ~clk;

  pure_pursuit_path_tracker DUT (.*);

  ppt_tracker_check u_check (.*);

  task automatic send_word(input bit tick, input int idx, input int xv, input int yv,
                           input int hd, input int spd, input int acc, input int tm);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    req_type <= tick;
    point_index <= idx[9:0];
    x_pos <= xv[23:0];
    y_pos <= yv[23:0];
    heading <= hd[15:0];
    point_speed <= spd[19:0];
    point_accel <= acc[19:0];
    time_ms <= tm;
    start <= 1;
    do @(posedge clk); while (busy);
    if (tick) tick_words++;
    else load_words++;
  endtask

  task automatic load_point(input int idx, input int xv, input int yv,
                            input int spd, input int acc);
    path_x[idx[9:0]] = 32'(signed'(xv[23:0]));
    path_y[idx[9:0]] = 32'(signed'(yv[23:0]));
    send_word(0, idx, xv, yv, $urandom, spd, acc, $urandom);
  endtask

  task automatic pose_tick(input int xv, input int yv, input int hd, input int tm);
    send_word(1, $urandom, xv, yv, hd, $urandom, $urandom, tm);
  endtask

  // Registers change only with no result word outstanding.
  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    reg_writes++;
  endtask

  function automatic int rand_signed(input int bits);
    return int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
  endfunction

  task automatic lay_path(input int n);
    int x0, y0, sx, sy;
    x0 = int'($urandom_range(0, 8000000)) - 4000000;
    y0 = int'($urandom_range(0, 8000000)) - 4000000;
    sx = int'($urandom_range(0, 800)) - 400;
    sy = int'($urandom_range(0, 800)) - 400;
    for (int i = 0; i < n; i++) begin
      load_point(i, x0 + i * sx + int'($urandom_range(0, 60)) - 30,
                 y0 + i * sy + int'($urandom_range(0, 60)) - 30,
                 ($urandom_range(9) == 0) ? rand_signed(20) : rand_signed(14),
                 rand_signed(20));
    end
  endtask

  task automatic follow_path(input int n, input int ticks);
    int k, lastp, r, tm, spread, pick;
    lastp = n - 1;
    k = 0;
    tm = $urandom;
    for (int t = 0; t < ticks; t++) begin
      r = $urandom_range(99);
      if (t == ticks / 2 && $urandom_range(1)) begin
        // Shrink the path mid-run so the saved nearest point can fall past the end.
        lastp = $urandom_range(1, lastp);
        write_reg(CFG_POINT_COUNT, lastp + 1);
      end
      if (r < 8) begin
        pose_tick(rand_signed(24), rand_signed(24), $urandom, $urandom);
      end else if (r < 13) begin
        load_point($urandom_range(1023), rand_signed(24), rand_signed(24),
                   rand_signed(20), rand_signed(20));
      end else begin
        spread = (r < 22) ? 4000 : 150;
        tm += (r < 25) ? int'($urandom_range(200, 2000)) : 10;
        pick = (k > lastp) ? lastp : k;
        pose_tick(path_x[pick] + int'($urandom_range(0, 2 * spread)) - spread,
                  path_y[pick] + int'($urandom_range(0, 2 * spread)) - spread,
                  $urandom, tm);
        k += $urandom_range(0, 2);
        if (k > lastp + 3) k = 0;
      end
    end
  endtask

  function automatic cfg_word_t pick_word(input cfg_word_t hi, input int lo_r, input int hi_r);
    case ($urandom_range(3))
      0: return '0;
      1: return hi;
      default: return $urandom_range(lo_r, hi_r);
    endcase
  endfunction

  initial begin
    int n;
    idle_pct = 38;
    tick_words = 0;
    load_words = 0;
    reg_writes = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty path, extreme points and registers, start too far,
    // zero lookahead with success, timeout and bail.
    pose_tick(0, 0, 0, 0);
    write_reg(CFG_POINT_COUNT, 1);
    pose_tick(0, 0, 0, 0);
    load_point(0, 8388607, -8388608, 524287, -524288);
    load_point(1, -8388608, 8388607, -524288, 524287);
    write_reg(CFG_POINT_COUNT, 2);
    write_reg(CFG_LOOKAHEAD, 0);
    write_reg(CFG_TRACK_WIDTH, 65535);
    write_reg(CFG_BAIL_DIST, 20'hFFFFF);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    pose_tick(0, 0, 0, 0);
    pose_tick(8388607, -8388608, 65535, 32'hFFFF_FFF0);
    pose_tick(-8388608, 8388607, 32768, 5);
    write_reg(CFG_TIMEOUT, 1);
    pose_tick(8388607, -8388608, 16384, 100);
    pose_tick(8388607, -8388608, 49152, 102);
    write_reg(CFG_TIMEOUT, 0);
    write_reg(CFG_BAIL_DIST, 0);
    pose_tick(8388606, -8388608, 1, 200);
    pose_tick(8388606, -8388608, 2, 210);
    pose_tick(8388606, -8388608, 3, 400);
    write_reg(CFG_POINT_COUNT, 11'h7FF);
    write_reg(CFG_LOOKAHEAD, 65535);

    // The full store once, with the count above its cap.
    lay_path(1024);
    pose_tick(path_x[0], path_y[0], $urandom, 1000);
    pose_tick(path_x[3], path_y[3], $urandom, 1010);
    pose_tick(path_x[70], path_y[70], $urandom, 1020);

    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 38 : ((ph < 6) ? 64 : 0);
      write_reg(CFG_LOOKAHEAD, pick_word(16'hFFFF, 128, 4096));
      write_reg(CFG_TRACK_WIDTH, pick_word(16'hFFFF, 1000, 8000));
      write_reg(CFG_BAIL_DIST, pick_word(20'hFFFFF, 300, 3000));
      write_reg(CFG_TIMEOUT, ($urandom_range(3) == 0) ? pick_word('1, 30, 400) : '0);
      n = $urandom_range(2, 30);
      lay_path(n);
      write_reg(CFG_POINT_COUNT, n);
      follow_path(n, 26);
    end

    write_reg(CFG_POINT_COUNT, 0);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d pose ticks and %0d point loads across %0d register writes,",
             tick_words, load_words, reg_writes);
    $display("with %0d result words compared field by field.", words_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Run did not finish in time.");
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ppt_pkg.sv
rtl/core/ppt_ram.sv
rtl/core/ppt_sqrt.sv
rtl/core/ppt_div.sv
rtl/core/pure_pursuit_path_tracker.sv
rtl/core/ppt_checker.sv
tb/ppt_tracker_check.sv
tb/tb_top.sv
